>>> rtl/tsar_pkg.sv
package tsar_pkg;

    // Ring depth of the moving average
    localparam int AVERAGE_DEPTH = 8;

    // Derived widths
    localparam int PTR_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int CNT_W = $clog2(AVERAGE_DEPTH + 1);
    localparam int TEMP_MAG_MAX = 150;
    localparam int SUM_MAG_W = $clog2(TEMP_MAG_MAX * AVERAGE_DEPTH + 1);
    localparam int SUM_W = SUM_MAG_W + 1;
    localparam int BIT_W = (SUM_MAG_W > 1) ? $clog2(SUM_MAG_W) : 1;
    localparam int ALU_W = 34;

    // Stream widths
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_DATA_W = 32;

    // Conversion constants: celsius = (adc - 2048) / 20 + 25
    localparam logic [11:0] ADC_OFFSET = 12'd2048;
    localparam logic [7:0] CELSIUS_BASE = 8'd25;
    localparam logic [11:0] RECIP_20 = 12'd3277;   // 65536 / 20 rounded up
    localparam int RECIP_SHIFT = 16;
    localparam int TEMP_MIN = -50;
    localparam int TEMP_MAX = 150;

    // Message id sequence
    localparam logic [5:0] EID_FIRST = 6'd30;
    localparam logic [5:0] EID_LAST = 6'd39;

    // Alert flag bits
    localparam int FLAG_HIGH_BIT = 0;
    localparam int FLAG_LOW_BIT = 1;

    // Report kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_HIGH_ALERT = 3'd1;
    localparam logic [2:0] KIND_HIGH_CLEAR = 3'd2;
    localparam logic [2:0] KIND_LOW_ALERT = 3'd3;
    localparam logic [2:0] KIND_LOW_CLEAR = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_LOW_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_CHANGE_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd3;

endpackage

>>> rtl/temperature_smoothing_alarm_reporter.sv
// Temperature smoothing and alarm reporter.
//
// Input stream (s_*): one request per ADC sample. s_tdata carries adc_sample
// and now_ms, s_tuser carries the measuring flag. A zero or out-of-range
// sample is dropped with no result.
// Output stream (m_*): alert events (each sent twice) and then one status
// result; m_tlast marks the status result, the last one of the request.
// Configuration: cfg_wr_en/cfg_addr/cfg_wr_data write the thresholds and
// the interval; write only while the block is idle.
//
// Timing: a request is accepted only in the idle state. A shared add/sub
// unit runs the conversion, the ring sum (one entry a cycle), a restoring
// division (one quotient bit a cycle, over the SUM_MAG_W bits of the sum)
// and the compares. After the report decision, results go out one per
// cycle while m_tready is high. If the receiver stalls, results hold in the
// output register and the sequencer waits; the next request may be accepted
// while the final status result is still waiting.
// Reset (aresetn low, synchronous) clears the ring pointer, alert state,
// report history and configuration to defaults; ring contents are not
// cleared, only written entries are ever averaged.
module temperature_smoothing_alarm_reporter
    import tsar_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample, [43:12] now_ms
    input  logic                   s_tuser,   // [0] measuring
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] message_id, [14:6] temperature,
                                              // [16:15] alert_flags
    output logic [2:0]             m_tuser,   // [2:0] report_kind
    output logic                   m_tlast,
    // Configuration
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_OFFS   = 5'd1;
    localparam logic [4:0] S_ABS    = 5'd2;
    localparam logic [4:0] S_MUL    = 5'd3;
    localparam logic [4:0] S_CELS   = 5'd4;
    localparam logic [4:0] S_SUM    = 5'd5;
    localparam logic [4:0] S_SABS   = 5'd6;
    localparam logic [4:0] S_DIV    = 5'd7;
    localparam logic [4:0] S_SIGN   = 5'd8;
    localparam logic [4:0] S_CMPH   = 5'd9;
    localparam logic [4:0] S_CMPL   = 5'd10;
    localparam logic [4:0] S_DIFF   = 5'd11;
    localparam logic [4:0] S_ADIFF  = 5'd12;
    localparam logic [4:0] S_SIG    = 5'd13;
    localparam logic [4:0] S_ELAP   = 5'd14;
    localparam logic [4:0] S_INTV   = 5'd15;
    localparam logic [4:0] S_DECIDE = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    // Emission steps
    localparam logic [2:0] STEP_HIGH_A = 3'd0;
    localparam logic [2:0] STEP_HIGH_B = 3'd1;
    localparam logic [2:0] STEP_LOW_A  = 3'd2;
    localparam logic [2:0] STEP_LOW_B  = 3'd3;
    localparam logic [2:0] STEP_STATUS = 3'd4;

    logic [4:0] state_reg, state_next;

    // Request registers
    logic [11:0] adc_reg, adc_next;
    logic [31:0] now_reg, now_next;
    logic meas_reg, meas_next;

    // Working registers
    logic signed [12:0] x_reg, x_next;
    logic [11:0] mag_reg, mag_next;
    logic [7:0] q_reg, q_next;
    logic neg_reg, neg_next;
    logic signed [8:0] ring_reg [AVERAGE_DEPTH];
    logic ring_we;
    logic signed [8:0] ring_wdata;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic full_reg, full_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_MAG_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic signed [8:0] avg_reg, avg_next;
    logic hnew_reg, hnew_next;
    logic lnew_reg, lnew_next;
    logic signed [9:0] diff_reg, diff_next;
    logic sig_reg, sig_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic intv_reg, intv_next;

    // Alert and report history
    logic high_reg, high_next;
    logic low_reg, low_next;
    logic signed [8:0] last_temp_reg, last_temp_next;
    logic never_reg, never_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [5:0] eid_reg, eid_next;
    logic [5:0] out_eid_reg, out_eid_next;
    logic hchg_reg, hchg_next;
    logic lchg_reg, lchg_next;
    logic [2:0] step_reg, step_next;

    // Output register
    logic m_valid_reg, m_valid_next;
    logic [2:0] m_kind_reg, m_kind_next;
    logic [5:0] m_id_reg, m_id_next;
    logic signed [8:0] m_temp_reg, m_temp_next;
    logic [1:0] m_flags_reg, m_flags_next;
    logic m_last_reg, m_last_next;

    // Configuration
    logic signed [8:0] high_thr_reg;
    logic signed [8:0] low_thr_reg;
    logic [7:0] change_thr_reg;
    logic [31:0] max_int_reg;

    // Shared add/sub unit
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic alu_sub;
    logic alu_neg;

    logic [23:0] product;
    logic [CNT_W:0] trial;
    logic trial_ge;
    logic [CNT_W-1:0] idx_ext;
    logic [PTR_W-1:0] wp_inc;
    logic [1:0] flags;
    logic alert_change;
    logic load_out;

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[ALU_W-1];

    assign product = mag_reg * RECIP_20;
    assign trial = {rem_reg, num_reg[SUM_MAG_W-1]};
    assign trial_ge = !alu_neg;
    assign idx_ext = CNT_W'(idx_reg);
    assign wp_inc = (wp_reg == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign alert_change = (hnew_reg != high_reg) || (lnew_reg != low_reg);
    assign ring_wdata = alu_res[8:0];

    always_comb begin
        flags = '0;
        flags[FLAG_HIGH_BIT] = high_reg;
        flags[FLAG_LOW_BIT] = low_reg;
    end

    // Operand selection for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_OFFS: begin
                alu_a = ALU_W'(adc_reg);
                alu_b = ALU_W'(ADC_OFFSET);
            end
            S_ABS: begin
                alu_b = ALU_W'(x_reg);
                alu_sub = x_reg[12];
            end
            S_CELS: begin
                alu_a = ALU_W'(CELSIUS_BASE);
                alu_b = ALU_W'(q_reg);
                alu_sub = neg_reg;
            end
            S_SUM: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(ring_reg[idx_reg]);
                alu_sub = 1'b0;
            end
            S_SABS: begin
                alu_b = ALU_W'(acc_reg);
                alu_sub = acc_reg[SUM_W-1];
            end
            S_DIV: begin
                alu_a = ALU_W'(trial);
                alu_b = ALU_W'(count_reg);
            end
            S_SIGN: begin
                alu_b = ALU_W'(num_reg);
                alu_sub = neg_reg;
            end
            S_CMPH: begin
                alu_a = ALU_W'(avg_reg);
                alu_b = ALU_W'(high_thr_reg);
            end
            S_CMPL: begin
                alu_a = ALU_W'(low_thr_reg);
                alu_b = ALU_W'(avg_reg);
            end
            S_DIFF: begin
                alu_a = ALU_W'(avg_reg);
                alu_b = ALU_W'(last_temp_reg);
            end
            S_ADIFF: begin
                alu_b = ALU_W'(diff_reg);
                alu_sub = diff_reg[9];
            end
            S_SIG: begin
                alu_a = ALU_W'(diff_reg);
                alu_b = ALU_W'(change_thr_reg);
            end
            S_ELAP: begin
                alu_a = ALU_W'(now_reg);
                alu_b = ALU_W'(last_time_reg);
            end
            S_INTV: begin
                alu_a = ALU_W'(elapsed_reg);
                alu_b = ALU_W'(max_int_reg);
            end
            default: begin
                alu_sub = 1'b1;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        adc_next = adc_reg;
        now_next = now_reg;
        meas_next = meas_reg;
        x_next = x_reg;
        mag_next = mag_reg;
        q_next = q_reg;
        neg_next = neg_reg;
        ring_we = 1'b0;
        wp_next = wp_reg;
        full_next = full_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        acc_next = acc_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        avg_next = avg_reg;
        hnew_next = hnew_reg;
        lnew_next = lnew_reg;
        diff_next = diff_reg;
        sig_next = sig_reg;
        elapsed_next = elapsed_reg;
        intv_next = intv_reg;
        high_next = high_reg;
        low_next = low_reg;
        last_temp_next = last_temp_reg;
        never_next = never_reg;
        last_time_next = last_time_reg;
        eid_next = eid_reg;
        out_eid_next = out_eid_reg;
        hchg_next = hchg_reg;
        lchg_next = lchg_reg;
        step_next = step_reg;
        load_out = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    adc_next = s_tdata[11:0];
                    now_next = s_tdata[43:12];
                    meas_next = s_tuser;
                    state_next = (s_tdata[11:0] == 12'd0) ? S_IDLE : S_OFFS;
                end
            end
            S_OFFS: begin
                x_next = alu_res[12:0];
                state_next = S_ABS;
            end
            S_ABS: begin
                mag_next = alu_res[11:0];
                neg_next = x_reg[12];
                state_next = S_MUL;
            end
            S_MUL: begin
                // truncating divide by 20 via reciprocal, exact for |x| <= 2048
                q_next = 8'(product >> RECIP_SHIFT);
                state_next = S_CELS;
            end
            S_CELS: begin
                if (alu_res < ALU_W'(TEMP_MIN) || alu_res > ALU_W'(TEMP_MAX)) begin
                    state_next = S_IDLE;
                end else begin
                    ring_we = 1'b1;
                    wp_next = wp_inc;
                    if (wp_inc == '0) begin
                        full_next = 1'b1;
                    end
                    count_next = (full_reg || wp_inc == '0) ?
                                 CNT_W'(AVERAGE_DEPTH) : CNT_W'(wp_inc);
                    acc_next = '0;
                    idx_next = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                acc_next = alu_res[SUM_W-1:0];
                idx_next = idx_reg + PTR_W'(1);
                if (idx_ext + CNT_W'(1) == count_reg) begin
                    state_next = S_SABS;
                end
            end
            S_SABS: begin
                num_next = alu_res[SUM_MAG_W-1:0];
                neg_next = acc_reg[SUM_W-1];
                rem_next = '0;
                bit_next = BIT_W'(SUM_MAG_W - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                // one restoring step: quotient bit shifts in at the bottom
                rem_next = trial_ge ? alu_res[CNT_W-1:0] : trial[CNT_W-1:0];
                num_next = {num_reg[SUM_MAG_W-2:0], trial_ge};
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0) begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN: begin
                avg_next = alu_res[8:0];
                state_next = S_CMPH;
            end
            S_CMPH: begin
                hnew_next = !alu_neg;
                state_next = S_CMPL;
            end
            S_CMPL: begin
                lnew_next = !alu_neg;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                diff_next = alu_res[9:0];
                state_next = S_ADIFF;
            end
            S_ADIFF: begin
                diff_next = alu_res[9:0];
                state_next = S_SIG;
            end
            S_SIG: begin
                sig_next = never_reg || !alu_neg;
                state_next = S_ELAP;
            end
            S_ELAP: begin
                elapsed_next = alu_res[31:0];
                state_next = S_INTV;
            end
            S_INTV: begin
                intv_next = !alu_neg;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                // alert state follows the average even when not reporting
                high_next = hnew_reg;
                low_next = lnew_reg;
                hchg_next = hnew_reg != high_reg;
                lchg_next = lnew_reg != low_reg;
                state_next = S_IDLE;
                if (meas_reg && (alert_change || sig_reg || intv_reg || never_reg)) begin
                    out_eid_next = eid_reg;
                    if (alert_change) begin
                        if (eid_reg inside {[EID_FIRST:EID_LAST - 6'd1]}) begin
                            eid_next = eid_reg + 6'd1;
                        end else begin
                            eid_next = EID_FIRST;
                        end
                    end
                    last_temp_next = avg_reg;
                    last_time_next = now_reg;
                    never_next = 1'b0;
                    if (hnew_reg != high_reg) begin
                        step_next = STEP_HIGH_A;
                    end else if (lnew_reg != low_reg) begin
                        step_next = STEP_LOW_A;
                    end else begin
                        step_next = STEP_STATUS;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out = 1'b1;
                    if (step_reg == STEP_STATUS) begin
                        state_next = S_IDLE;
                    end else if (step_reg == STEP_HIGH_B && !lchg_reg) begin
                        step_next = STEP_STATUS;
                    end else begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register load
    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next = m_kind_reg;
        m_id_next = m_id_reg;
        m_temp_next = m_temp_reg;
        m_flags_next = m_flags_reg;
        m_last_next = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_flags_next = flags;
            case (step_reg)
                STEP_HIGH_A, STEP_HIGH_B: begin
                    m_kind_next = high_reg ? KIND_HIGH_ALERT : KIND_HIGH_CLEAR;
                    m_id_next = out_eid_reg;
                    m_temp_next = '0;
                    m_last_next = 1'b0;
                end
                STEP_LOW_A, STEP_LOW_B: begin
                    m_kind_next = low_reg ? KIND_LOW_ALERT : KIND_LOW_CLEAR;
                    m_id_next = out_eid_reg;
                    m_temp_next = '0;
                    m_last_next = 1'b0;
                end
                default: begin
                    m_kind_next = KIND_STATUS;
                    m_id_next = '0;
                    m_temp_next = avg_reg;
                    m_last_next = 1'b1;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wp_reg <= '0;
            full_reg <= 1'b0;
            high_reg <= 1'b0;
            low_reg <= 1'b0;
            last_temp_reg <= '0;
            never_reg <= 1'b1;
            last_time_reg <= '0;
            eid_reg <= EID_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg <= wp_next;
            full_reg <= full_next;
            high_reg <= high_next;
            low_reg <= low_next;
            last_temp_reg <= last_temp_next;
            never_reg <= never_next;
            last_time_reg <= last_time_next;
            eid_reg <= eid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        adc_reg <= adc_next;
        now_reg <= now_next;
        meas_reg <= meas_next;
        x_reg <= x_next;
        mag_reg <= mag_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
        count_reg <= count_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        avg_reg <= avg_next;
        hnew_reg <= hnew_next;
        lnew_reg <= lnew_next;
        diff_reg <= diff_next;
        sig_reg <= sig_next;
        elapsed_reg <= elapsed_next;
        intv_reg <= intv_next;
        out_eid_reg <= out_eid_next;
        hchg_reg <= hchg_next;
        lchg_reg <= lchg_next;
        step_reg <= step_next;
        m_kind_reg <= m_kind_next;
        m_id_reg <= m_id_next;
        m_temp_reg <= m_temp_next;
        m_flags_reg <= m_flags_next;
        m_last_reg <= m_last_next;
    end

    // Sample ring
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_reg[wp_reg] <= ring_wdata;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= 9'sd85;
            low_thr_reg <= -9'sd10;
            change_thr_reg <= 8'd1;
            max_int_reg <= 32'd10000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HIGH_THRESHOLD:   high_thr_reg <= cfg_wr_data[8:0];
                REG_LOW_THRESHOLD:    low_thr_reg <= cfg_wr_data[8:0];
                REG_CHANGE_THRESHOLD: change_thr_reg <= cfg_wr_data[7:0];
                REG_MAX_INTERVAL:     max_int_reg <= cfg_wr_data[31:0];
                default:              max_int_reg <= max_int_reg;
            endcase
        end
    end

    // Ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;
    assign m_tdata = {7'd0, m_flags_reg, m_temp_reg, m_id_reg};

`ifndef SYNTHESIS
    // The status result, and only it, closes a request
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("tlast does not match status kind");

    // Alert events carry a message id of the sequence
    a_alert_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_STATUS) |->
        (m_tdata[5:0] >= EID_FIRST && m_tdata[5:0] <= EID_LAST))
        else $error("alert message id out of sequence");

    // The ring sum only reads entries already written
    a_sum_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> (count_reg != '0 && idx_ext < count_reg))
        else $error("ring sum reads past fill count");

    // Division remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < count_reg))
        else $error("division remainder not below count");

    // A nonzero sample request starts the conversion
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[11:0] != 12'd0) |=> (state_reg == S_OFFS))
        else $error("accepted sample did not start conversion");
`endif

endmodule
